FILE: design/stbs_pkg.sv
// Shared types and constants for the sorted table binary search core.
// Used by stbs_ctrl, stbs_datapath and sorted_table_binary_search_core.
`default_nettype none

package stbs_pkg;

    localparam int DATA_W    = 32;  // table entry and target width
    localparam int IDX_W     = 12;  // flat entry index width on the input channel
    localparam int REG_W     = 7;   // width of each size register
    localparam int CNT_W     = 14;  // holds up to 127 * 127 used entries
    localparam int CLAMP_W   = 11;  // holds the largest row or column limit
    localparam int WIDE_W    = 21;  // holds the largest store depth
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_ROWS_IN_USE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COLS_IN_USE = 2'd1;

    localparam logic ACT_LOAD   = 1'b0;
    localparam logic ACT_SEARCH = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_READ = 4'b0010,
        ST_CMP  = 4'b0100,
        ST_DONE = 4'b1000
    } t_state;

    // Controller to datapath
    typedef struct packed {
        logic load;      // write the accepted entry into the table
        logic capture;   // latch target and open the search range
        logic rd_en;     // read the table at the midpoint
        logic step;      // narrow the range after a miss
        logic mark_hit;  // record a match
        logic emit;      // move the answer into the output register
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic empty;      // live range holds no entry
        logic hit;        // probed entry equals the target
        logic slot_free;  // output register can take a new answer
    } t_status;

endpackage

`default_nettype wire

FILE: design/stbs_ctrl.sv
// Search sequencer: one-hot state machine that steps the binary search.
// Depends on stbs_pkg; drives the command struct of stbs_datapath.
`default_nettype none

module stbs_ctrl (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_in_valid,
    input  wire logic            i_action,
    output logic                 o_in_stall,
    input  wire stbs_pkg::t_status i_status,
    output stbs_pkg::t_cmd       o_cmd
);

    stbs_pkg::t_state r_state;
    stbs_pkg::t_state n_state;
    logic             w_accept;

    assign o_in_stall = (r_state != stbs_pkg::ST_IDLE);
    assign w_accept   = i_in_valid && (r_state == stbs_pkg::ST_IDLE);

    always_comb begin
        o_cmd.load     = w_accept && (i_action == stbs_pkg::ACT_LOAD);
        o_cmd.capture  = w_accept && (i_action == stbs_pkg::ACT_SEARCH);
        o_cmd.rd_en    = (r_state == stbs_pkg::ST_READ) && !i_status.empty;
        o_cmd.step     = (r_state == stbs_pkg::ST_CMP) && !i_status.hit;
        o_cmd.mark_hit = (r_state == stbs_pkg::ST_CMP) && i_status.hit;
        o_cmd.emit     = (r_state == stbs_pkg::ST_DONE) && i_status.slot_free;
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            stbs_pkg::ST_IDLE: begin
                if (o_cmd.capture) begin
                    n_state = stbs_pkg::ST_READ;
                end
            end
            stbs_pkg::ST_READ: begin
                n_state = i_status.empty ? stbs_pkg::ST_DONE : stbs_pkg::ST_CMP;
            end
            stbs_pkg::ST_CMP: begin
                n_state = i_status.hit ? stbs_pkg::ST_DONE : stbs_pkg::ST_READ;
            end
            stbs_pkg::ST_DONE: begin
                if (i_status.slot_free) begin
                    n_state = stbs_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = stbs_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= stbs_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

FILE: design/stbs_datapath.sv
// Datapath: value table, size registers, search range, compare and result register.
// Depends on stbs_pkg; steered by stbs_ctrl through the command struct.
`default_nettype none

module stbs_datapath #(
    parameter int MAX_ROWS = 64,
    parameter int MAX_COLS = 64
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire stbs_pkg::t_cmd                    i_cmd,
    output stbs_pkg::t_status                      o_status,
    input  wire logic [stbs_pkg::IDX_W-1:0]        i_entry_index,
    input  wire logic signed [stbs_pkg::DATA_W-1:0] i_data_value,
    input  wire logic                              i_cfg_we,
    input  wire logic [stbs_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [stbs_pkg::REG_W-1:0]        i_cfg_data,
    input  wire logic                              i_out_stall,
    output logic                                   o_out_valid,
    output logic                                   o_found
);

    localparam int DEPTH = MAX_ROWS * MAX_COLS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [stbs_pkg::CLAMP_W-1:0] MAX_R_L = stbs_pkg::CLAMP_W'(MAX_ROWS);
    localparam logic [stbs_pkg::CLAMP_W-1:0] MAX_C_L = stbs_pkg::CLAMP_W'(MAX_COLS);
    localparam logic [stbs_pkg::WIDE_W-1:0]  DEPTH_L = stbs_pkg::WIDE_W'(DEPTH);

    logic [stbs_pkg::DATA_W-1:0] r_mem [DEPTH];
    logic [stbs_pkg::DATA_W-1:0] r_rd_data;

    logic [stbs_pkg::REG_W-1:0]  r_rows;
    logic [stbs_pkg::REG_W-1:0]  r_cols;
    logic [stbs_pkg::REG_W-1:0]  w_rows_eff;
    logic [stbs_pkg::REG_W-1:0]  w_cols_eff;
    logic [stbs_pkg::CNT_W-1:0]  w_count;

    logic signed [stbs_pkg::DATA_W-1:0] r_target;
    logic [stbs_pkg::CNT_W-1:0]  r_lo;
    logic [stbs_pkg::CNT_W-1:0]  r_hi;
    logic [stbs_pkg::CNT_W-1:0]  w_mid;
    logic [stbs_pkg::WIDE_W-1:0] w_mid_wide;
    logic [stbs_pkg::WIDE_W-1:0] w_wr_wide;
    logic                        w_wr_en;
    logic                        w_greater;
    logic                        r_found;

    // Size registers, clamped to the table limits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows <= stbs_pkg::REG_W'(1);
            r_cols <= stbs_pkg::REG_W'(1);
        end else if (i_cfg_we) begin
            if (i_cfg_index == stbs_pkg::CFG_ROWS_IN_USE) begin
                r_rows <= i_cfg_data;
            end else if (i_cfg_index == stbs_pkg::CFG_COLS_IN_USE) begin
                r_cols <= i_cfg_data;
            end
        end
    end

    assign w_rows_eff = (stbs_pkg::CLAMP_W'(r_rows) > MAX_R_L)
                        ? MAX_R_L[stbs_pkg::REG_W-1:0] : r_rows;
    assign w_cols_eff = (stbs_pkg::CLAMP_W'(r_cols) > MAX_C_L)
                        ? MAX_C_L[stbs_pkg::REG_W-1:0] : r_cols;
    assign w_count    = stbs_pkg::CNT_W'(w_rows_eff) * stbs_pkg::CNT_W'(w_cols_eff);

    // Table: one write port for loads, one registered read port for probes
    assign w_wr_wide = stbs_pkg::WIDE_W'(i_entry_index);
    assign w_wr_en   = i_cmd.load && (w_wr_wide < DEPTH_L);

    assign w_mid      = r_lo + ((r_hi - r_lo - stbs_pkg::CNT_W'(1)) >> 1);
    assign w_mid_wide = stbs_pkg::WIDE_W'(w_mid);

    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[w_wr_wide[AW-1:0]] <= i_data_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_en) begin
            r_rd_data <= r_mem[w_mid_wide[AW-1:0]];
        end
    end

    // Search range
    assign w_greater = $signed(r_rd_data) > r_target;

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_target <= i_data_value;
            r_lo     <= '0;
            r_hi     <= w_count;
        end else if (i_cmd.step) begin
            if (w_greater) begin
                r_hi <= w_mid;
            end else begin
                r_lo <= w_mid + stbs_pkg::CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_found <= 1'b0;
        end else if (i_cmd.capture) begin
            r_found <= 1'b0;
        end else if (i_cmd.mark_hit) begin
            r_found <= 1'b1;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            o_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            o_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            o_found <= r_found;
        end
    end

    always_comb begin
        o_status.empty     = !(r_lo < r_hi);
        o_status.hit       = (r_rd_data == r_target);
        o_status.slot_free = !o_out_valid || !i_out_stall;
    end

endmodule

`default_nettype wire

FILE: design/sorted_table_binary_search_core.sv
// Sorted table binary search core: top level, joins stbs_ctrl and stbs_datapath.
// Load: accepted when idle and written on that edge, no result; one per cycle while idle.
// Search: each probe is a registered table read (ST_READ), then a compare (ST_CMP); the
//   search ends in ST_DONE, which holds while a full output register is stalled, and the
//   core takes no new transaction until the search has returned to idle.
// Reset (synchronous, active low) clears control state and sets both sizes to one.
`default_nettype none

module sorted_table_binary_search_core #(
    parameter int MAX_ROWS = 64,
    parameter int MAX_COLS = 64
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    // Input channel
    input  wire logic                               i_in_valid,
    output logic                                    o_in_stall,
    input  wire logic                               i_action,
    input  wire logic [stbs_pkg::IDX_W-1:0]         i_entry_index,
    input  wire logic signed [stbs_pkg::DATA_W-1:0] i_data_value,
    // Result channel
    output logic                                    o_out_valid,
    input  wire logic                               i_out_stall,
    output logic                                    o_found,
    // Configuration write channel
    input  wire logic                               i_cfg_valid,
    output logic                                    o_cfg_ready,
    input  wire logic [stbs_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire logic [stbs_pkg::REG_W-1:0]         i_cfg_data
);

    stbs_pkg::t_cmd    w_cmd;
    stbs_pkg::t_status w_status;
    logic              w_cfg_we;

    // Sizes take writes on any cycle with no check; user must write only while idle.
    assign o_cfg_ready = 1'b1;
    assign w_cfg_we    = i_cfg_valid && o_cfg_ready;

    // Sequencer: accept a transaction when idle, step probes, hand off the answer
    stbs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_action   (i_action),
        .o_in_stall (o_in_stall),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    // Table, search range and output register. The output register parts the
    // result side from the input side, so loads and new searches are taken
    // while an answer still waits downstream.
    stbs_datapath #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_status      (w_status),
        .i_entry_index (i_entry_index),
        .i_data_value  (i_data_value),
        .i_cfg_we      (w_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_out_stall   (i_out_stall),
        .o_out_valid   (o_out_valid),
        .o_found       (o_found)
    );

endmodule

`default_nettype wire
